>>> sv/torus_signed_distance_unit_assert.svh
// Assertion macros for the torus signed distance unit.
`ifndef TORUS_SIGNED_DISTANCE_UNIT_ASSERT_SVH
`define TORUS_SIGNED_DISTANCE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TSD_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tsd_pkg.sv
// Shared widths, register indexes and square root step for the torus distance unit.
`default_nettype none
package tsd_pkg;
	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int AXIS_W    = FRAC_W + 2;
	localparam int RAD_W     = COORD_W - 1;
	localparam int CFG_IDX_W = 4;
	localparam int DIFF_W    = 33;
	localparam int PROD_W    = 51;
	localparam int DOT_W     = 53;
	localparam int HGT_W     = 37;
	localparam int HPROD_W   = 55;
	localparam int VEC_W     = 40;
	localparam int MAG_W     = 37;
	localparam int LIM_W     = 31;
	localparam int SHIFT_W   = 3;
	localparam int SQ_W      = 62;
	localparam int SUM_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int RING_W    = 38;
	localparam int OFS_W     = 40;
	localparam int MAG2_W    = 38;
	localparam int DIST_W    = 39;
	localparam int RES_W     = 41;

	localparam int SQRT_STEPS_PER_STAGE = 2;
	localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;
	localparam int SQRT1_SIDE_W         = SHIFT_W + HGT_W;
	localparam int SQRT2_SIDE_W         = SHIFT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MINOR    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MAJOR    = 4'd7;

	localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [SUM_W-1:0] root;
	} sqrt_state_t;

	// Advance the digit-by-digit square root by one stage's worth of steps.
	function automatic sqrt_state_t sqrt_steps(sqrt_state_t st, int unsigned stage);
		sqrt_state_t r;
		logic [SUM_W-1:0] bitv;
		logic [SUM_W-1:0] trial;
		r = st;
		for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
			bitv = {{(SUM_W-1){1'b0}}, 1'b1} << (SUM_W - 2 - 2 * (stage * SQRT_STEPS_PER_STAGE + j));
			trial = r.root + bitv;
			if (r.rem >= trial) begin
				r.rem = r.rem - trial;
				r.root = (r.root >> 1) + bitv;
			end else begin
				r.root = r.root >> 1;
			end
		end
		return r;
	endfunction

	// Least right shift that brings every component below 2^LIM_W (v is the OR of them).
	function automatic logic [SHIFT_W-1:0] scale_shift(logic [SUM_W-1:0] v);
		int k;
		k = 0;
		for (int i = LIM_W; i < SUM_W; i++) begin
			if (v[i]) begin
				k = i - LIM_W + 1;
			end
		end
		return SHIFT_W'(k);
	endfunction
endpackage
`default_nettype wire

>>> sv/torus_signed_distance_unit.sv
// Torus signed distance unit: each accepted point yields one signed distance result word.
// Throughput one point per cycle unless a result stalls; two 16-stage square root pipelines set the depth.
// A stalled result freezes the whole pipeline, so input stall follows output stall.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register defaults:
// unit z axis, center at origin, minor radius 1.0, major radius 2.0.
`default_nettype none
module torus_signed_distance_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tsd_pkg::COORD_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [tsd_pkg::COORD_W-1:0]    point_x,
	input  logic signed [tsd_pkg::COORD_W-1:0]    point_y,
	input  logic signed [tsd_pkg::COORD_W-1:0]    point_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [tsd_pkg::COORD_W-1:0]    signed_distance,
	output logic                                  saturated
);
	localparam int FB = tsd_pkg::FRAC_W;

	logic signed [tsd_pkg::AXIS_W-1:0]  axis_x_q, axis_y_q, axis_z_q;
	logic signed [tsd_pkg::COORD_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [tsd_pkg::RAD_W-1:0]          minor_q, major_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q   <= '0;
			axis_y_q   <= '0;
			axis_z_q   <= tsd_pkg::AXIS_W'(1 << FB);
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			minor_q    <= tsd_pkg::RAD_W'(1 << FB);
			major_q    <= tsd_pkg::RAD_W'(2 << FB);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tsd_pkg::CFG_AXIS_X:   axis_x_q   <= cfg_data[tsd_pkg::AXIS_W-1:0];
				tsd_pkg::CFG_AXIS_Y:   axis_y_q   <= cfg_data[tsd_pkg::AXIS_W-1:0];
				tsd_pkg::CFG_AXIS_Z:   axis_z_q   <= cfg_data[tsd_pkg::AXIS_W-1:0];
				tsd_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				tsd_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				tsd_pkg::CFG_CENTER_Z: center_z_q <= cfg_data;
				tsd_pkg::CFG_MINOR:    minor_q    <= cfg_data[tsd_pkg::RAD_W-1:0];
				tsd_pkg::CFG_MAJOR:    major_q    <= cfg_data[tsd_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves as one; hold everything while the result word waits.
	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12, v_s13;
	logic sq1_valid, sq2_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= sq1_valid; v_s10 <= v_s9; v_s11 <= v_s10; v_s12 <= v_s11;
			v_s13 <= sq2_valid;
		end
	end

	// Stage 1: offset from center.
	logic signed [tsd_pkg::DIFF_W-1:0] sx_s1, sy_s1, sz_s1;
	// Stage 2: axis products.
	logic signed [tsd_pkg::PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic signed [tsd_pkg::DIFF_W-1:0] sx_s2, sy_s2, sz_s2;
	// Stage 3: height.
	logic signed [tsd_pkg::HGT_W-1:0]  h_s3;
	logic signed [tsd_pkg::DIFF_W-1:0] sx_s3, sy_s3, sz_s3;
	// Stage 4: height times axis.
	logic signed [tsd_pkg::HPROD_W-1:0] hx_s4, hy_s4, hz_s4;
	logic signed [tsd_pkg::HGT_W-1:0]   h_s4;
	logic signed [tsd_pkg::DIFF_W-1:0]  sx_s4, sy_s4, sz_s4;
	// Stage 5: in-plane magnitudes.
	logic [tsd_pkg::MAG_W-1:0]         mx_s5, my_s5, mz_s5;
	logic signed [tsd_pkg::HGT_W-1:0]  h_s5;
	// Stage 6: scaled components.
	logic [tsd_pkg::LIM_W-1:0]         ax_s6, ay_s6, az_s6;
	logic [tsd_pkg::SHIFT_W-1:0]       k_s6;
	logic signed [tsd_pkg::HGT_W-1:0]  h_s6;
	// Stage 7: squares.
	logic [tsd_pkg::SQ_W-1:0]          qx_s7, qy_s7, qz_s7;
	logic [tsd_pkg::SHIFT_W-1:0]       k_s7;
	logic signed [tsd_pkg::HGT_W-1:0]  h_s7;
	// Stage 8: sum of squares.
	logic [tsd_pkg::SUM_W-1:0]         sum_s8;
	logic [tsd_pkg::SHIFT_W-1:0]       k_s8;
	logic signed [tsd_pkg::HGT_W-1:0]  h_s8;

	logic signed [tsd_pkg::DOT_W-1:0] dot;
	logic signed [tsd_pkg::VEC_W-1:0] vx, vy, vz;
	logic [tsd_pkg::VEC_W-1:0]        ux, uy, uz;
	logic [tsd_pkg::SUM_W-1:0]        mor;
	logic [tsd_pkg::SHIFT_W-1:0]      kk;

	always_comb begin
		dot = tsd_pkg::DOT_W'(px_s2) + tsd_pkg::DOT_W'(py_s2) + tsd_pkg::DOT_W'(pz_s2);
		vx = tsd_pkg::VEC_W'(sx_s4) - tsd_pkg::VEC_W'(hx_s4 >>> FB);
		vy = tsd_pkg::VEC_W'(sy_s4) - tsd_pkg::VEC_W'(hy_s4 >>> FB);
		vz = tsd_pkg::VEC_W'(sz_s4) - tsd_pkg::VEC_W'(hz_s4 >>> FB);
		ux = (vx < 0) ? -vx : vx;
		uy = (vy < 0) ? -vy : vy;
		uz = (vz < 0) ? -vz : vz;
		mor = tsd_pkg::SUM_W'(mx_s5 | my_s5 | mz_s5);
		kk = tsd_pkg::scale_shift(mor);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= tsd_pkg::DIFF_W'(point_x) - tsd_pkg::DIFF_W'(center_x_q);
			sy_s1 <= tsd_pkg::DIFF_W'(point_y) - tsd_pkg::DIFF_W'(center_y_q);
			sz_s1 <= tsd_pkg::DIFF_W'(point_z) - tsd_pkg::DIFF_W'(center_z_q);

			px_s2 <= tsd_pkg::PROD_W'(sx_s1) * tsd_pkg::PROD_W'(axis_x_q);
			py_s2 <= tsd_pkg::PROD_W'(sy_s1) * tsd_pkg::PROD_W'(axis_y_q);
			pz_s2 <= tsd_pkg::PROD_W'(sz_s1) * tsd_pkg::PROD_W'(axis_z_q);
			sx_s2 <= sx_s1; sy_s2 <= sy_s1; sz_s2 <= sz_s1;

			h_s3  <= tsd_pkg::HGT_W'(dot >>> FB);
			sx_s3 <= sx_s2; sy_s3 <= sy_s2; sz_s3 <= sz_s2;

			hx_s4 <= tsd_pkg::HPROD_W'(h_s3) * tsd_pkg::HPROD_W'(axis_x_q);
			hy_s4 <= tsd_pkg::HPROD_W'(h_s3) * tsd_pkg::HPROD_W'(axis_y_q);
			hz_s4 <= tsd_pkg::HPROD_W'(h_s3) * tsd_pkg::HPROD_W'(axis_z_q);
			h_s4  <= h_s3;
			sx_s4 <= sx_s3; sy_s4 <= sy_s3; sz_s4 <= sz_s3;

			mx_s5 <= ux[tsd_pkg::MAG_W-1:0];
			my_s5 <= uy[tsd_pkg::MAG_W-1:0];
			mz_s5 <= uz[tsd_pkg::MAG_W-1:0];
			h_s5  <= h_s4;

			ax_s6 <= tsd_pkg::LIM_W'(mx_s5 >> kk);
			ay_s6 <= tsd_pkg::LIM_W'(my_s5 >> kk);
			az_s6 <= tsd_pkg::LIM_W'(mz_s5 >> kk);
			k_s6  <= kk;
			h_s6  <= h_s5;

			qx_s7 <= tsd_pkg::SQ_W'(ax_s6) * tsd_pkg::SQ_W'(ax_s6);
			qy_s7 <= tsd_pkg::SQ_W'(ay_s6) * tsd_pkg::SQ_W'(ay_s6);
			qz_s7 <= tsd_pkg::SQ_W'(az_s6) * tsd_pkg::SQ_W'(az_s6);
			k_s7  <= k_s6;
			h_s7  <= h_s6;

			sum_s8 <= tsd_pkg::SUM_W'(qx_s7) + tsd_pkg::SUM_W'(qy_s7) + tsd_pkg::SUM_W'(qz_s7);
			k_s8   <= k_s7;
			h_s8   <= h_s7;
		end
	end

	logic [tsd_pkg::ROOT_W-1:0]       root1;
	logic [tsd_pkg::SQRT1_SIDE_W-1:0] side1;

	tsd_sqrt_pipe #(
		.SIDE_W(tsd_pkg::SQRT1_SIDE_W)
	) u_ring_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.in_n     (sum_s8),
		.in_side  ({k_s8, h_s8}),
		.out_valid(sq1_valid),
		.out_root (root1),
		.out_side (side1)
	);

	// Stages 9 to 12: tube offset, second scaling, squares, sum.
	logic [tsd_pkg::MAG2_W-1:0]   mq_s9, mh_s9;
	logic [tsd_pkg::LIM_W-1:0]    aq_s10, ah_s10;
	logic [tsd_pkg::SHIFT_W-1:0]  k_s10, k_s11, k_s12;
	logic [tsd_pkg::SQ_W-1:0]     qq_s11, qh_s11;
	logic [tsd_pkg::SUM_W-1:0]    sum_s12;

	logic [tsd_pkg::SHIFT_W-1:0]       k1;
	logic signed [tsd_pkg::HGT_W-1:0]  h1;
	logic [tsd_pkg::RING_W-1:0]        ring;
	logic signed [tsd_pkg::OFS_W-1:0]  q, hx;
	logic [tsd_pkg::OFS_W-1:0]         uq, uh;
	logic [tsd_pkg::SUM_W-1:0]         mor2;
	logic [tsd_pkg::SHIFT_W-1:0]       kk2;

	always_comb begin
		k1   = side1[tsd_pkg::SQRT1_SIDE_W-1 -: tsd_pkg::SHIFT_W];
		h1   = side1[tsd_pkg::HGT_W-1:0];
		ring = tsd_pkg::RING_W'(root1) << k1;
		q    = $signed(tsd_pkg::OFS_W'(ring)) - $signed(tsd_pkg::OFS_W'(major_q));
		hx   = tsd_pkg::OFS_W'(h1);
		uq   = (q < 0) ? -q : q;
		uh   = (hx < 0) ? -hx : hx;
		mor2 = tsd_pkg::SUM_W'(mq_s9 | mh_s9);
		kk2  = tsd_pkg::scale_shift(mor2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mq_s9 <= uq[tsd_pkg::MAG2_W-1:0];
			mh_s9 <= uh[tsd_pkg::MAG2_W-1:0];

			aq_s10 <= tsd_pkg::LIM_W'(mq_s9 >> kk2);
			ah_s10 <= tsd_pkg::LIM_W'(mh_s9 >> kk2);
			k_s10  <= kk2;

			qq_s11 <= tsd_pkg::SQ_W'(aq_s10) * tsd_pkg::SQ_W'(aq_s10);
			qh_s11 <= tsd_pkg::SQ_W'(ah_s10) * tsd_pkg::SQ_W'(ah_s10);
			k_s11  <= k_s10;

			sum_s12 <= tsd_pkg::SUM_W'(qq_s11) + tsd_pkg::SUM_W'(qh_s11);
			k_s12   <= k_s11;
		end
	end

	logic [tsd_pkg::ROOT_W-1:0]       root2;
	logic [tsd_pkg::SQRT2_SIDE_W-1:0] side2;

	tsd_sqrt_pipe #(
		.SIDE_W(tsd_pkg::SQRT2_SIDE_W)
	) u_dist_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s12),
		.in_n     (sum_s12),
		.in_side  (k_s12),
		.out_valid(sq2_valid),
		.out_root (root2),
		.out_side (side2)
	);

	// Stage 13: radius minus distance, clip to the output range.
	logic [tsd_pkg::DIST_W-1:0]       dist_len;
	logic signed [tsd_pkg::RES_W-1:0] res;
	logic signed [tsd_pkg::COORD_W-1:0] dist_val_s13;
	logic                               sat_s13;

	always_comb begin
		dist_len = tsd_pkg::DIST_W'(root2) << side2;
		res      = $signed(tsd_pkg::RES_W'(minor_q)) - $signed(tsd_pkg::RES_W'(dist_len));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (res > tsd_pkg::RES_W'(tsd_pkg::SAT_MAX)) begin
				dist_val_s13 <= tsd_pkg::SAT_MAX;
				sat_s13      <= 1'b1;
			end else if (res < tsd_pkg::RES_W'(tsd_pkg::SAT_MIN)) begin
				dist_val_s13 <= tsd_pkg::SAT_MIN;
				sat_s13      <= 1'b1;
			end else begin
				dist_val_s13 <= res[tsd_pkg::COORD_W-1:0];
				sat_s13      <= 1'b0;
			end
		end
	end

	assign out_valid       = v_s13;
	assign signed_distance = dist_val_s13;
	assign saturated       = sat_s13;

`include "torus_signed_distance_unit_assert.svh"

	`TSD_ASSERT_HOLDS(a_sat_clips, out_valid && saturated, signed_distance == tsd_pkg::SAT_MAX || signed_distance == tsd_pkg::SAT_MIN, "saturated word not at a range limit")
	`TSD_ASSERT_HOLDS(a_stall_source, in_stall, out_valid && out_stall, "input stalled without a waiting result")
	`TSD_ASSERT_NEXT(a_freeze, in_stall, out_valid && $stable(signed_distance) && $stable(saturated), "pipeline moved while stalled")
endmodule
`default_nettype wire

>>> sv/tsd_sqrt_pipe.sv
// Pipelined integer square root, two result bits per stage, with a side word riding along.
`default_nettype none
module tsd_sqrt_pipe #(
	parameter int SIDE_W = tsd_pkg::SQRT2_SIDE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [tsd_pkg::SUM_W-1:0]   in_n,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [tsd_pkg::ROOT_W-1:0]  out_root,
	output logic [SIDE_W-1:0]           out_side
);
	localparam int STAGES = tsd_pkg::SQRT_STAGES;

	tsd_pkg::sqrt_state_t st_s   [STAGES];
	logic [SIDE_W-1:0]    side_s [STAGES];
	logic                 v_s    [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		tsd_pkg::sqrt_state_t prev;
		logic [SIDE_W-1:0]    prev_side;
		logic                 prev_v;
		if (i == 0) begin : g_first
			assign prev      = '{rem: in_n, root: '0};
			assign prev_side = in_side;
			assign prev_v    = in_valid;
		end else begin : g_next
			assign prev      = st_s[i-1];
			assign prev_side = side_s[i-1];
			assign prev_v    = v_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i]   <= tsd_pkg::sqrt_steps(prev, i);
				side_s[i] <= prev_side;
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_root  = st_s[STAGES-1].root[tsd_pkg::ROOT_W-1:0];
	assign out_side  = side_s[STAGES-1];
endmodule
`default_nettype wire
